// File: src/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared types, codes and constants of the HSV color converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsvc_pkg;

	localparam int HUE_W  = 11;
	localparam int GAIN_W = 12;
	localparam int CFG_W  = 12;
	localparam int IDX_W  = 1;
	localparam int SECT_W = 3;
	localparam int FRAC_W = 8;

	localparam logic [11:0] HUE_FULL = 12'd1536;
	localparam logic [11:0] HUE_SECT2 = 12'd512;
	localparam logic [11:0] HUE_SECT4 = 12'd1024;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;

	localparam logic [IDX_W-1:0] REG_MODE = 1'b0;
	localparam logic [IDX_W-1:0] REG_GAIN = 1'b1;

	typedef enum logic [1:0] {
		MODE_RGB2HSV = 2'd0,
		MODE_HSV2RGB = 2'd1,
		MODE_SAT_ADJ = 2'd2
	} mode_t;

	// per-sector candidates: value, low (p), rising (t), falling (q)
	typedef enum logic [1:0] {
		VAL_V = 2'd0,
		VAL_P = 2'd1,
		VAL_T = 2'd2,
		VAL_Q = 2'd3
	} val_sel_t;

	typedef struct packed {
		val_sel_t r_sel;
		val_sel_t g_sel;
		val_sel_t b_sel;
	} pick_t;

	function automatic pick_t sector_pick(input logic [SECT_W-1:0] sector);
		pick_t p;
		case (sector)
			3'd0: p = '{VAL_V, VAL_T, VAL_P};
			3'd1: p = '{VAL_Q, VAL_V, VAL_P};
			3'd2: p = '{VAL_P, VAL_V, VAL_T};
			3'd3: p = '{VAL_P, VAL_Q, VAL_V};
			3'd4: p = '{VAL_T, VAL_P, VAL_V};
			3'd5: p = '{VAL_V, VAL_P, VAL_Q};
			default: p = '{VAL_V, VAL_T, VAL_P};
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// File: src/hsv_color_converter.sv
// ----------------------------------------------------------------------------
// hsv_color_converter
// Per-pixel RGB/HSV converter with saturation adjust, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a pixel item is taken at a clock edge with start high; busy is
//   tied low, so a new item can be taken every cycle (one item per clock).
//   Output: each result is shown for one cycle with done high; the receiver
//   cannot stall and nothing waits, so no item is ever dropped or held.
//   Path: capture, operand and divider-feed registers, then the HSV divider
//   pipeline, one quotient bit per stage, shared in depth by the saturation
//   and hue divides; the RGB candidates divide by constants through
//   reciprocal multiplies in a single stage, followed by a result register.
//   Config: cfg_valid/cfg_ready write port, cfg_ready always high. Index 0
//   is the conversion mode (low two data bits), index 1 the Q4.8 saturation
//   gain. Write only while the pipe is empty; the mode is sampled per item.
//   Reset: clears all valid bits, mode to rgb-to-hsv, gain to 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsv_color_converter #(
	parameter int CHANNEL_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [CHANNEL_BITS-1:0]         red_in,
	input  wire logic [CHANNEL_BITS-1:0]         green_in,
	input  wire logic [CHANNEL_BITS-1:0]         blue_in,
	input  wire logic [hsvc_pkg::HUE_W-1:0]      hue_in,
	input  wire logic [CHANNEL_BITS-1:0]         sat_in,
	input  wire logic [CHANNEL_BITS-1:0]         value_in,
	input  wire logic [CHANNEL_BITS-1:0]         alpha_in,
	output logic                                 done,
	output logic [CHANNEL_BITS-1:0]              red_out,
	output logic [CHANNEL_BITS-1:0]              green_out,
	output logic [CHANNEL_BITS-1:0]              blue_out,
	output logic [hsvc_pkg::HUE_W-1:0]           hue_out,
	output logic [CHANNEL_BITS-1:0]              sat_out,
	output logic [CHANNEL_BITS-1:0]              value_out,
	output logic [CHANNEL_BITS-1:0]              alpha_out,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [hsvc_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [hsvc_pkg::CFG_W-1:0]      cfg_data
);

	localparam int N    = CHANNEL_BITS;
	localparam int HW   = hsvc_pkg::HUE_W;
	localparam int GW   = hsvc_pkg::GAIN_W;
	localparam int HQ_W = (N > 9) ? N : 9;

	localparam logic [N-1:0]   CH_MAX  = {N{1'b1}};
	// 1.0 in the hue-fraction products: CH_MAX * 256
	localparam logic [N+7:0]   RGB_DEN = {CH_MAX, 8'd0};

	// divider widths
	localparam int SX_W = 2 * N + 2;
	localparam int HX_W = N + 10;
	localparam int DY_W = N + 1;

	localparam int SIDE_A = 2 + GW + 1 + N + HW + 3 * N;
	localparam int SIDE_H = 13;

	// ---------------- configuration ----------------
	logic [1:0]    mode_q;
	logic [GW-1:0] gain_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hsvc_pkg::MODE_RGB2HSV;
			gain_q <= hsvc_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == hsvc_pkg::REG_MODE) mode_q <= cfg_data[1:0];
			else if (cfg_index == hsvc_pkg::REG_GAIN) mode_q <= mode_q;
			if (cfg_index == hsvc_pkg::REG_GAIN) gain_q <= cfg_data[GW-1:0];
		end
	end

	// ---------------- s1: capture ----------------
	logic          vld_s1;
	logic [1:0]    mode_s1;
	logic [GW-1:0] gain_s1;
	logic [N-1:0]  r_s1, g_s1, b_s1, sin_s1, vin_s1, a_s1;
	logic [HW-1:0] hin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode_q;
		gain_s1 <= gain_q;
		r_s1    <= red_in;
		g_s1    <= green_in;
		b_s1    <= blue_in;
		hin_s1  <= hue_in;
		sin_s1  <= sat_in;
		vin_s1  <= value_in;
		a_s1    <= alpha_in;
	end

	// max / min and the hue sector term
	logic [N-1:0] mx, mn, diff;
	logic         neg;
	logic [11:0]  base;

	always_comb begin
		mx = r_s1;
		mn = r_s1;
		if (g_s1 > mx) mx = g_s1;
		if (b_s1 > mx) mx = b_s1;
		if (g_s1 < mn) mn = g_s1;
		if (b_s1 < mn) mn = b_s1;
		if (r_s1 >= mx) begin
			if (g_s1 >= b_s1) begin
				diff = g_s1 - b_s1; neg = 1'b0; base = '0;
			end else begin
				diff = b_s1 - g_s1; neg = 1'b1; base = hsvc_pkg::HUE_FULL;
			end
		end else if (g_s1 >= mx) begin
			base = hsvc_pkg::HUE_SECT2;
			if (b_s1 >= r_s1) begin
				diff = b_s1 - r_s1; neg = 1'b0;
			end else begin
				diff = r_s1 - b_s1; neg = 1'b1;
			end
		end else begin
			base = hsvc_pkg::HUE_SECT4;
			if (r_s1 >= g_s1) begin
				diff = r_s1 - g_s1; neg = 1'b0;
			end else begin
				diff = g_s1 - r_s1; neg = 1'b1;
			end
		end
	end

	// ---------------- s2 ----------------
	logic          vld_s2, neg_s2;
	logic [1:0]    mode_s2;
	logic [GW-1:0] gain_s2;
	logic [11:0]   base_s2;
	logic [N-1:0]  mx_s2, delta_s2, diff_s2, sin_s2, vin_s2, a_s2;
	logic [HW-1:0] hin_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		mode_s2  <= mode_s1;
		gain_s2  <= gain_s1;
		base_s2  <= base;
		neg_s2   <= neg;
		mx_s2    <= mx;
		delta_s2 <= mx - mn;
		diff_s2  <= diff;
		hin_s2   <= hin_s1;
		sin_s2   <= sin_s1;
		vin_s2   <= vin_s1;
		a_s2     <= a_s1;
	end

	// rounded-divide operands: (2n + d) / (2d)
	logic [SX_W-1:0] sat_x;
	logic [HX_W-1:0] hue_x;

	assign sat_x = ((SX_W'({delta_s2, {N{1'b0}}}) - SX_W'(delta_s2)) << 1) + SX_W'(mx_s2);
	assign hue_x = HX_W'({diff_s2, 9'd0}) + HX_W'(delta_s2);

	// ---------------- s3: divider feed ----------------
	logic              vld_s3;
	logic [SX_W-1:0]   sat_x_s3;
	logic [HX_W-1:0]   hue_x_s3;
	logic [DY_W-1:0]   sat_y_s3, hue_y_s3;
	logic [SIDE_A-1:0] side_a_s3;
	logic [SIDE_H-1:0] side_h_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		sat_x_s3  <= sat_x;
		sat_y_s3  <= {mx_s2, 1'b0};
		hue_x_s3  <= hue_x;
		hue_y_s3  <= {delta_s2, 1'b0};
		side_a_s3 <= {mode_s2, gain_s2, (delta_s2 == '0), mx_s2, hin_s2,
			sin_s2, vin_s2, a_s2};
		side_h_s3 <= {base_s2, neg_s2};
	end

	logic              sd_valid, hd_valid;
	logic [HQ_W-1:0]   sat_q, hue_q;
	logic [SIDE_A-1:0] side_a;
	logic [SIDE_H-1:0] side_h;

	hsvc_div #(.X_W(SX_W), .Y_W(DY_W), .Q_W(HQ_W), .SIDE_W(SIDE_A)) u_sat_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3), .x(sat_x_s3), .y(sat_y_s3),
		.side_in(side_a_s3), .out_valid(sd_valid), .q(sat_q), .side_out(side_a)
	);

	hsvc_div #(.X_W(HX_W), .Y_W(DY_W), .Q_W(HQ_W), .SIDE_W(SIDE_H)) u_hue_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3), .x(hue_x_s3), .y(hue_y_s3),
		.side_in(side_h_s3), .out_valid(hd_valid), .q(hue_q), .side_out(side_h)
	);

	logic [1:0]    d_mode;
	logic [GW-1:0] d_gain;
	logic          d_grey, d_neg;
	logic [N-1:0]  d_mx, d_sin, d_vin, d_a;
	logic [HW-1:0] d_hin;
	logic [11:0]   d_base;

	assign {d_mode, d_gain, d_grey, d_mx, d_hin, d_sin, d_vin, d_a} = side_a;
	assign {d_base, d_neg} = side_h;

	// hue with wrap, grey forces zero hue and saturation
	logic [11:0]   hue_raw, hue_wr;
	logic [N-1:0]  sat_v;

	always_comb begin
		hue_raw = d_neg ? d_base - 12'(hue_q[8:0]) : d_base + 12'(hue_q[8:0]);
		hue_wr  = (hue_raw >= hsvc_pkg::HUE_FULL) ? hue_raw - hsvc_pkg::HUE_FULL : hue_raw;
		if (d_grey) hue_wr = '0;
		sat_v = d_grey ? '0 : sat_q[N-1:0];
	end

	// ---------------- s4: HSV done, gain product ----------------
	logic            vld_s4;
	logic [1:0]      mode_s4;
	logic [HW-1:0]   hue_s4, hin_s4;
	logic [N-1:0]    sat_s4, mx_s4, sin_s4, vin_s4, a_s4;
	logic [N+GW-1:0] prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= sd_valid && hd_valid;
	end

	always_ff @(posedge clk) begin
		mode_s4 <= d_mode;
		hue_s4  <= hue_wr[HW-1:0];
		sat_s4  <= sat_v;
		prod_s4 <= (N+GW)'(sat_v) * (N+GW)'(d_gain);
		mx_s4   <= d_mx;
		hin_s4  <= d_hin;
		sin_s4  <= d_sin;
		vin_s4  <= d_vin;
		a_s4    <= d_a;
	end

	// round the Q4.8 product, clamp, and pick the HSV source for RGB
	logic [N+GW:0]   prod_rnd;
	logic [N-1:0]    sadj, s_sel, v_sel;
	logic [HW-1:0]   hin_wr, h_sel;

	always_comb begin
		prod_rnd = (N+GW+1)'(prod_s4) + (N+GW+1)'(128);
		sadj = (prod_rnd[N+GW:8] > (N+GW-7)'(CH_MAX)) ? CH_MAX : prod_rnd[N+7:8];
		hin_wr = (hin_s4 >= HW'(hsvc_pkg::HUE_FULL))
			? hin_s4 - HW'(hsvc_pkg::HUE_FULL) : hin_s4;
		if (mode_s4 == hsvc_pkg::MODE_HSV2RGB) begin
			h_sel = hin_wr; s_sel = sin_s4; v_sel = vin_s4;
		end else begin
			h_sel = hue_s4; s_sel = sadj; v_sel = mx_s4;
		end
	end

	// ---------------- s5 ----------------
	logic                      vld_s5;
	logic [1:0]                mode_s5;
	logic [hsvc_pkg::SECT_W-1:0] sect_s5;
	logic [hsvc_pkg::FRAC_W-1:0] frac_s5;
	logic [N-1:0]              s_s5, v_s5, sat_o_s5, val_o_s5, a_s5;
	logic [HW-1:0]             hue_o_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		mode_s5  <= mode_s4;
		sect_s5  <= h_sel[HW-1:8];
		frac_s5  <= h_sel[7:0];
		s_s5     <= s_sel;
		v_s5     <= v_sel;
		hue_o_s5 <= hue_s4;
		sat_o_s5 <= sat_s4;
		val_o_s5 <= mx_s4;
		a_s5     <= a_s4;
	end

	// ---------------- s6: first products ----------------
	logic                      vld_s6, zero_s6;
	logic [1:0]                mode_s6;
	logic [hsvc_pkg::SECT_W-1:0] sect_s6;
	logic [2*N-1:0]            p1_s6;
	logic [N+8:0]              t2_s6, t3_s6;
	logic [N-1:0]              v_s6, sat_o_s6, val_o_s6, a_s6;
	logic [HW-1:0]             hue_o_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		mode_s6  <= mode_s5;
		sect_s6  <= sect_s5;
		zero_s6  <= (s_s5 == '0);
		p1_s6    <= (2*N)'(v_s5) * (2*N)'(CH_MAX - s_s5);
		t2_s6    <= (N+9)'(s_s5) * ((N+9)'(9'd256) - (N+9)'(frac_s5));
		t3_s6    <= (N+9)'(s_s5) * (N+9)'(frac_s5);
		v_s6     <= v_s5;
		hue_o_s6 <= hue_o_s5;
		sat_o_s6 <= sat_o_s5;
		val_o_s6 <= val_o_s5;
		a_s6     <= a_s5;
	end

	logic [N+8:0] d2_full, d3_full;

	assign d2_full = (N+9)'(RGB_DEN) - t2_s6;
	assign d3_full = (N+9)'(RGB_DEN) - t3_s6;

	// ---------------- s7: second products ----------------
	logic                      vld_s7, zero_s7;
	logic [1:0]                mode_s7;
	logic [hsvc_pkg::SECT_W-1:0] sect_s7;
	logic [2*N-1:0]            p1_s7;
	logic [2*N+7:0]            p2_s7, p3_s7;
	logic [N-1:0]              v_s7, sat_o_s7, val_o_s7, a_s7;
	logic [HW-1:0]             hue_o_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		mode_s7  <= mode_s6;
		sect_s7  <= sect_s6;
		zero_s7  <= zero_s6;
		p1_s7    <= p1_s6;
		p2_s7    <= (2*N+8)'(v_s6) * (2*N+8)'(d2_full[N+7:0]);
		p3_s7    <= (2*N+8)'(v_s6) * (2*N+8)'(d3_full[N+7:0]);
		v_s7     <= v_s6;
		hue_o_s7 <= hue_o_s6;
		sat_o_s7 <= sat_o_s6;
		val_o_s7 <= val_o_s6;
		a_s7     <= a_s6;
	end

	// round(n / M) = floor((n + (M-1)/2) / M). For the M*256 divisor the
	// rounding add is M*128 and the low 8 bits drop before the divide by M.
	// floor(m / M) = (m * RCP_K) >> 3N for every m below 2^2N.
	localparam logic [N-1:0] HALF_P = {1'b0, {(N-1){1'b1}}};
	localparam logic [N+6:0] HALF_T = {CH_MAX, 7'd0};
	localparam logic [2*N:0] RCP_K  = {1'b1, {(2*N){1'b0}}}
		+ {{N{1'b0}}, 1'b1, {N{1'b0}}} + (2*N+1)'(2);

	logic [2*N-1:0] m1, m2, m3;
	logic [2*N+7:0] t2_rnd, t3_rnd;

	assign m1     = p1_s7 + (2*N)'(HALF_P);
	assign t2_rnd = p2_s7 + (2*N+8)'(HALF_T);
	assign t3_rnd = p3_s7 + (2*N+8)'(HALF_T);
	assign m2     = t2_rnd[2*N+7:8];
	assign m3     = t3_rnd[2*N+7:8];

	// ---------------- s8: reciprocal products ----------------
	logic                        vld_s8, zero_s8;
	logic [1:0]                  mode_s8;
	logic [hsvc_pkg::SECT_W-1:0] sect_s8;
	logic [4*N-1:0]              rp_s8, rt_s8, rq_s8;
	logic [N-1:0]                v_s8, sat_o_s8, val_o_s8, a_s8;
	logic [HW-1:0]               hue_o_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		mode_s8  <= mode_s7;
		sect_s8  <= sect_s7;
		zero_s8  <= zero_s7;
		rp_s8    <= (4*N)'(m1) * (4*N)'(RCP_K);
		rt_s8    <= (4*N)'(m2) * (4*N)'(RCP_K);
		rq_s8    <= (4*N)'(m3) * (4*N)'(RCP_K);
		v_s8     <= v_s7;
		hue_o_s8 <= hue_o_s7;
		sat_o_s8 <= sat_o_s7;
		val_o_s8 <= val_o_s7;
		a_s8     <= a_s7;
	end

	logic [N-1:0] val_p, val_t, val_q;

	assign val_p = rp_s8[4*N-1:3*N];
	assign val_t = rt_s8[4*N-1:3*N];
	assign val_q = rq_s8[4*N-1:3*N];

	function automatic logic [N-1:0] pick_val(input hsvc_pkg::val_sel_t sel,
		input logic [N-1:0] v, input logic [N-1:0] p,
		input logic [N-1:0] t, input logic [N-1:0] q);
		logic [N-1:0] res;
		case (sel)
			hsvc_pkg::VAL_V: res = v;
			hsvc_pkg::VAL_P: res = p;
			hsvc_pkg::VAL_T: res = t;
			hsvc_pkg::VAL_Q: res = q;
			default:         res = v;
		endcase
		return res;
	endfunction

	// sector table, grey override, then per-mode field mux
	hsvc_pkg::pick_t pk;
	logic [N-1:0]    rr, gg, bb;
	logic [N-1:0]    r_nx, g_nx, b_nx, s_nx, v_nx, a_nx;
	logic [HW-1:0]   h_nx;

	always_comb begin
		pk = hsvc_pkg::sector_pick(sect_s8);
		rr = pick_val(pk.r_sel, v_s8, val_p, val_t, val_q);
		gg = pick_val(pk.g_sel, v_s8, val_p, val_t, val_q);
		bb = pick_val(pk.b_sel, v_s8, val_p, val_t, val_q);
		if (zero_s8) begin
			rr = v_s8; gg = v_s8; bb = v_s8;
		end
		r_nx = '0; g_nx = '0; b_nx = '0;
		h_nx = '0; s_nx = '0; v_nx = '0;
		a_nx = a_s8;
		case (mode_s8)
			hsvc_pkg::MODE_RGB2HSV: begin
				h_nx = hue_o_s8; s_nx = sat_o_s8; v_nx = val_o_s8;
			end
			hsvc_pkg::MODE_HSV2RGB: begin
				r_nx = rr; g_nx = gg; b_nx = bb; a_nx = CH_MAX;
			end
			hsvc_pkg::MODE_SAT_ADJ: begin
				r_nx = rr; g_nx = gg; b_nx = bb;
			end
			default: begin
				a_nx = a_s8;
			end
		endcase
	end

	// ---------------- result register ----------------
	logic          done_q;
	logic [N-1:0]  red_q, green_q, blue_q, sat_q_o, value_q, alpha_q;
	logic [HW-1:0] hue_q_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= vld_s8;
	end

	always_ff @(posedge clk) begin
		red_q   <= r_nx;
		green_q <= g_nx;
		blue_q  <= b_nx;
		hue_q_o <= h_nx;
		sat_q_o <= s_nx;
		value_q <= v_nx;
		alpha_q <= a_nx;
	end

	assign done      = done_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign hue_out   = hue_q_o;
	assign sat_out   = sat_q_o;
	assign value_out = value_q;
	assign alpha_out = alpha_q;

endmodule

`default_nettype wire

// File: src/hsvc_div.sv
// ----------------------------------------------------------------------------
// hsvc_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvc_div #(
	parameter int X_W    = 16,
	parameter int Y_W    = 9,
	parameter int Q_W    = 8,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [X_W-1:0]    x,
	input  wire logic [Y_W-1:0]    y,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [Q_W-1:0]         q,
	output logic [SIDE_W-1:0]      side_out
);

	// remainder wide enough for y shifted by the top quotient bit
	localparam int RW = (X_W > Y_W + Q_W) ? X_W : (Y_W + Q_W);

	logic              vld_s  [Q_W];
	logic [RW-1:0]     rem_s  [Q_W];
	logic [Y_W-1:0]    den_s  [Q_W];
	logic [Q_W-1:0]    quo_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	logic              vld_in  [Q_W];
	logic [RW-1:0]     rem_in  [Q_W];
	logic [Y_W-1:0]    den_in  [Q_W];
	logic [Q_W-1:0]    quo_in  [Q_W];
	logic [SIDE_W-1:0] side_nx [Q_W];
	logic [RW:0]       trial   [Q_W];
	logic [RW-1:0]     rem_nx  [Q_W];
	logic [Q_W-1:0]    quo_nx  [Q_W];

	always_comb begin
		for (int i = 0; i < Q_W; i++) begin
			if (i == 0) begin
				vld_in[i]  = in_valid;
				rem_in[i]  = RW'(x);
				den_in[i]  = y;
				quo_in[i]  = '0;
				side_nx[i] = side_in;
			end else begin
				vld_in[i]  = vld_s[i-1];
				rem_in[i]  = rem_s[i-1];
				den_in[i]  = den_s[i-1];
				quo_in[i]  = quo_s[i-1];
				side_nx[i] = side_s[i-1];
			end
			trial[i] = {1'b0, rem_in[i]} - ((RW+1)'(den_in[i]) << (Q_W - 1 - i));
			rem_nx[i] = trial[i][RW] ? rem_in[i] : trial[i][RW-1:0];
			quo_nx[i] = quo_in[i];
			quo_nx[i][Q_W-1-i] = ~trial[i][RW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Q_W; i++) vld_s[i] <= 1'b0;
		end else begin
			for (int i = 0; i < Q_W; i++) vld_s[i] <= vld_in[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < Q_W; i++) begin
			rem_s[i]  <= rem_nx[i];
			den_s[i]  <= den_in[i];
			quo_s[i]  <= quo_nx[i];
			side_s[i] <= side_nx[i];
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign q         = quo_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hsv_color_converter: directed corner pixels and
// random pixels in every mode and several gains, scored against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [10:0] hue;
	logic [7:0]  sat;
	logic [7:0]  value;
	logic [7:0]  alpha;
} pixel_t;

// Predicts converter output per pixel and holds expected pixels in order.
class pixel_scoreboard;
	pixel_t          expected_q[$];
	int              error_count = 0;
	int              checked = 0;
	hsvc_pkg::mode_t mode = hsvc_pkg::MODE_RGB2HSV;
	int              gain = 256;

	function int rdiv(int num, int den);
		return (2 * num + den) / (2 * den);
	endfunction

	function void rgb_to_hsv(int r, int g, int b, output int h, output int s,
			output int v);
		int mx, mn, dl;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		dl = mx - mn;
		v = mx;
		if (dl == 0) begin
			h = 0; s = 0;
			return;
		end
		s = rdiv(dl * 255, mx);
		if (r >= mx) begin
			if (g >= b) h = rdiv(256 * (g - b), dl);
			else h = 1536 - rdiv(256 * (b - g), dl);
		end else if (g >= mx) begin
			if (b >= r) h = 512 + rdiv(256 * (b - r), dl);
			else h = 512 - rdiv(256 * (r - b), dl);
		end else begin
			if (r >= g) h = 1024 + rdiv(256 * (r - g), dl);
			else h = 1024 - rdiv(256 * (g - r), dl);
		end
		if (h >= 1536) h -= 1536;
	endfunction

	function void hsv_to_rgb(int h, int s, int v, output int r, output int g,
			output int b);
		int cand[4];
		int sector, frac, den;
		if (h >= 1536) h -= 1536;
		if (s == 0) begin
			r = v; g = v; b = v;
			return;
		end
		sector = h / 256;
		frac = h % 256;
		den = 255 * 256;
		cand[hsvc_pkg::VAL_V] = v;
		cand[hsvc_pkg::VAL_P] = rdiv(v * (255 - s), 255);
		cand[hsvc_pkg::VAL_T] = rdiv(v * (den - s * (256 - frac)), den);
		cand[hsvc_pkg::VAL_Q] = rdiv(v * (den - s * frac), den);
		case (sector)
			0: begin
				r = cand[hsvc_pkg::VAL_V]; g = cand[hsvc_pkg::VAL_T]; b = cand[hsvc_pkg::VAL_P];
			end
			1: begin
				r = cand[hsvc_pkg::VAL_Q]; g = cand[hsvc_pkg::VAL_V]; b = cand[hsvc_pkg::VAL_P];
			end
			2: begin
				r = cand[hsvc_pkg::VAL_P]; g = cand[hsvc_pkg::VAL_V]; b = cand[hsvc_pkg::VAL_T];
			end
			3: begin
				r = cand[hsvc_pkg::VAL_P]; g = cand[hsvc_pkg::VAL_Q]; b = cand[hsvc_pkg::VAL_V];
			end
			4: begin
				r = cand[hsvc_pkg::VAL_T]; g = cand[hsvc_pkg::VAL_P]; b = cand[hsvc_pkg::VAL_V];
			end
			default: begin
				r = cand[hsvc_pkg::VAL_V]; g = cand[hsvc_pkg::VAL_P]; b = cand[hsvc_pkg::VAL_Q];
			end
		endcase
	endfunction

	function void note_input(pixel_t px);
		pixel_t e;
		int r, g, b, h, s, v;
		e = '{default: '0};
		e.alpha = px.alpha;
		case (mode)
			hsvc_pkg::MODE_RGB2HSV: begin
				rgb_to_hsv(int'(px.red), int'(px.green), int'(px.blue), h, s, v);
				e.hue = 11'(h); e.sat = 8'(s); e.value = 8'(v);
			end
			hsvc_pkg::MODE_HSV2RGB: begin
				hsv_to_rgb(int'(px.hue), int'(px.sat), int'(px.value), r, g, b);
				e.red = 8'(r); e.green = 8'(g); e.blue = 8'(b);
				e.alpha = 8'd255;
			end
			hsvc_pkg::MODE_SAT_ADJ: begin
				rgb_to_hsv(int'(px.red), int'(px.green), int'(px.blue), h, s, v);
				s = rdiv(s * gain, 256);
				if (s > 255) s = 255;
				hsv_to_rgb(h, s, v, r, g, b);
				e.red = 8'(r); e.green = 8'(g); e.blue = 8'(b);
			end
			default: ;
		endcase
		expected_q.push_back(e);
	endfunction

	function void check_result(pixel_t got);
		pixel_t e;
		if (expected_q.size() == 0) begin
			$error("unexpected result, nothing pending");
			error_count++;
			return;
		end
		e = expected_q.pop_front();
		checked++;
		if (got.red !== e.red) begin
			$error("red_out exp %0d got %0d", e.red, got.red); error_count++;
		end
		if (got.green !== e.green) begin
			$error("green_out exp %0d got %0d", e.green, got.green); error_count++;
		end
		if (got.blue !== e.blue) begin
			$error("blue_out exp %0d got %0d", e.blue, got.blue); error_count++;
		end
		if (got.hue !== e.hue) begin
			$error("hue_out exp %0d got %0d", e.hue, got.hue); error_count++;
		end
		if (got.sat !== e.sat) begin
			$error("sat_out exp %0d got %0d", e.sat, got.sat); error_count++;
		end
		if (got.value !== e.value) begin
			$error("value_out exp %0d got %0d", e.value, got.value); error_count++;
		end
		if (got.alpha !== e.alpha) begin
			$error("alpha_out exp %0d got %0d", e.alpha, got.alpha); error_count++;
		end
	endfunction
endclass

module testbench;
	// idle margin waited out after the last drain, before the summary
	localparam int DRAIN_CYCLES = 40;
	localparam int IDX_W = hsvc_pkg::IDX_W;
	localparam int CFG_W = hsvc_pkg::CFG_W;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  red_in, green_in, blue_in, sat_in, value_in, alpha_in;
	logic [10:0] hue_in;
	logic        done;
	logic [7:0]  red_out, green_out, blue_out, sat_out, value_out, alpha_out;
	logic [10:0] hue_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	pixel_scoreboard board;
	int idle_pct;     // chance in percent that the sender idles a cycle
	int item_count;

	hsv_color_converter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.hue_in(hue_in), .sat_in(sat_in), .value_in(value_in),
		.alpha_in(alpha_in), .done(done),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.hue_out(hue_out), .sat_out(sat_out), .value_out(value_out),
		.alpha_out(alpha_out), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result sampling at the rising edge; done marks a one-cycle result.
	always @(posedge clk) begin
		pixel_t got;
		if (arst_n && done === 1'b1) begin
			got.red = red_out; got.green = green_out; got.blue = blue_out;
			got.hue = hue_out; got.sat = sat_out; got.value = value_out;
			got.alpha = alpha_out;
			board.check_result(got);
		end
	end

	// Send one pixel; start holds until an edge with busy low takes it.
	// Inputs only change on the falling edge.
	task automatic send_pixel(pixel_t px);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		red_in <= px.red; green_in <= px.green; blue_in <= px.blue;
		hue_in <= px.hue; sat_in <= px.sat; value_in <= px.value;
		alpha_in <= px.alpha;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		board.note_input(px);
		item_count++;
		@(negedge clk);
	endtask

	// Wait until every pending result is back; the pipe is then empty,
	// since every item gives exactly one result.
	task automatic drain;
		start <= 1'b0;
		while (board.expected_q.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		if (idx == hsvc_pkg::REG_MODE) board.mode = hsvc_pkg::mode_t'(data[1:0]);
		else board.gain = int'(data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.red = 8'($urandom); px.green = 8'($urandom); px.blue = 8'($urandom);
		px.hue = 11'($urandom); px.sat = 8'($urandom); px.value = 8'($urandom);
		px.alpha = 8'($urandom);
		// some greys and zero saturation now and then
		if ($urandom_range(9) == 0) begin
			px.green = px.red; px.blue = px.red;
		end
		if ($urandom_range(9) == 0) px.sat = 8'd0;
		return px;
	endfunction

	function automatic pixel_t mk(int r, int g, int b, int h, int s, int v,
			int a);
		pixel_t px;
		px.red = 8'(r); px.green = 8'(g); px.blue = 8'(b); px.hue = 11'(h);
		px.sat = 8'(s); px.value = 8'(v); px.alpha = 8'(a);
		return px;
	endfunction

	initial begin
		pixel_t directed[$];
		int gains[6];
		int modes_run[4];
		board = new();
		item_count = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{red_in, green_in, blue_in, sat_in, value_in, alpha_in} = '0;
		hue_in = '0;
		cfg_valid = 1'b0;
		cfg_index = hsvc_pkg::REG_MODE;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Corner pixels: extremes, grey, the red-max negative-hue wrap,
		// hue at and past the full circle, zero saturation, each sector.
		directed.push_back(mk(0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(255, 255, 255, 2047, 255, 255, 255));
		directed.push_back(mk(128, 128, 128, 1536, 0, 200, 17));
		directed.push_back(mk(255, 0, 1, 1535, 255, 255, 170));
		directed.push_back(mk(255, 0, 255, 1537, 128, 100, 85));
		directed.push_back(mk(255, 0, 0, 0, 255, 255, 1));
		directed.push_back(mk(0, 255, 0, 256, 255, 255, 2));
		directed.push_back(mk(0, 0, 255, 512, 200, 128, 4));
		directed.push_back(mk(10, 255, 200, 768, 1, 255, 8));
		directed.push_back(mk(200, 10, 255, 1024, 77, 33, 16));
		directed.push_back(mk(1, 2, 3, 1280, 254, 1, 32));
		directed.push_back(mk(254, 253, 0, 1791, 255, 254, 64));
		directed.push_back(mk(0, 1, 0, 255, 3, 255, 128));

		// Each directed pass runs in one mode; reset gain (1.0) used in mode 2.
		modes_run = '{int'(hsvc_pkg::MODE_RGB2HSV), int'(hsvc_pkg::MODE_HSV2RGB),
			int'(hsvc_pkg::MODE_SAT_ADJ), 3};
		foreach (modes_run[m]) begin
			write_reg(hsvc_pkg::REG_MODE, CFG_W'(modes_run[m]));
			foreach (directed[i]) send_pixel(directed[i]);
			drain();
		end

		// Random phases: gain sweep covers zero, unity, overflow and full scale.
		gains = '{0, 256, 4095, 100, 700, 2048};
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 57;
				2: idle_pct = 21;
				default: idle_pct = $urandom_range(10, 40);
			endcase
			write_reg(hsvc_pkg::REG_GAIN, CFG_W'(gains[ph % 6]));
			write_reg(hsvc_pkg::REG_MODE, CFG_W'((ph % 5 == 4) ? 3 : ph % 3));
			repeat (50) send_pixel(random_pixel());
			// let everything come back before the next setting
			drain();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Ran %0d pixels over all four modes and six gains; %0d results checked.",
			item_count, board.checked);
		if (board.error_count == 0 && board.expected_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

`default_nettype wire
